// File: sv/kctc_pkg.sv
// Package for the knob countdown timer controller.
// Holds event, mode and register codes, shared structs and small helpers.
// No dependencies.
package kctc_pkg;

	// Event kinds on the input channel.
	typedef enum logic [1:0] {
		OP_TICK   = 2'd0,
		OP_BUTTON = 2'd1,
		OP_WAKE   = 2'd2,
		OP_SAMPLE = 2'd3
	} op_t;

	// Operating mode, one-hot.
	typedef enum logic [2:0] {
		MODE_SETTING = 3'b001,
		MODE_WORKING = 3'b010,
		MODE_DOWN    = 3'b100
	} mode_t;

	// Mode codes as they appear on the result channel.
	localparam logic [1:0] MODE_CODE_SETTING = 2'd0;
	localparam logic [1:0] MODE_CODE_WORKING = 2'd1;
	localparam logic [1:0] MODE_CODE_DOWN    = 2'd2;

	// Configuration register indexes.
	localparam logic [2:0] CFG_TICKS_PER_SECOND    = 3'd0;
	localparam logic [2:0] CFG_BLINK_ON_TICKS      = 3'd1;
	localparam logic [2:0] CFG_BLINK_OFF_TICKS     = 3'd2;
	localparam logic [2:0] CFG_BEEP_ON_TICKS       = 3'd3;
	localparam logic [2:0] CFG_BEEP_PAUSE_TICKS    = 3'd4;
	localparam logic [2:0] CFG_IDLE_SETTING_TICKS  = 3'd5;
	localparam logic [2:0] CFG_IDLE_BEEPING_TICKS  = 3'd6;
	localparam logic [2:0] CFG_SAVER_DELAY_SECONDS = 3'd7;

	// Register reset values.
	localparam logic [15:0] RST_TICKS_PER_SECOND    = 16'd620;
	localparam logic [15:0] RST_BLINK_ON_TICKS      = 16'd300;
	localparam logic [15:0] RST_BLINK_OFF_TICKS     = 16'd100;
	localparam logic [15:0] RST_BEEP_ON_TICKS       = 16'd40;
	localparam logic [15:0] RST_BEEP_PAUSE_TICKS    = 16'd250;
	localparam logic [15:0] RST_IDLE_SETTING_TICKS  = 16'd6000;
	localparam logic [15:0] RST_IDLE_BEEPING_TICKS  = 16'd12000;
	localparam logic [7:0]  RST_SAVER_DELAY_SECONDS = 8'd3;

	// Minutes never exceed 95 with the default of 40 knob steps.
	localparam int MIN_W = 7;
	localparam int SEC_W = 6;

	typedef struct packed {
		logic [15:0] ticks_per_second;
		logic [15:0] blink_on_ticks;
		logic [15:0] blink_off_ticks;
		logic [15:0] beep_on_ticks;
		logic [15:0] beep_pause_ticks;
		logic [15:0] idle_setting_ticks;
		logic [15:0] idle_beeping_ticks;
		logic [7:0]  saver_delay_seconds;
	} cfg_t;

	// A time split into minutes and seconds.
	typedef struct packed {
		logic [MIN_W-1:0] minutes;
		logic [SEC_W-1:0] seconds;
	} mmss_t;

	// Knob unit status toward the timer.
	typedef struct packed {
		mmss_t cur;
		mmss_t nxt;
		logic  conv;
	} knob_stat_t;

	// One result transaction.
	typedef struct packed {
		logic [1:0]  mode;
		logic [13:0] shown_time;
		logic        digits_blank;
		logic        saver_active;
		logic [2:0]  saver_position;
		logic        beeper_on;
		logic        start_conversion;
		logic        enter_power_down;
	} res_t;

	// Saturating 16-bit increment.
	function automatic logic [15:0] inc_sat(input logic [15:0] v);
		return (v == 16'hFFFF) ? v : v + 16'd1;
	endfunction

	// Minutes times 100 plus seconds, by shifts and adds.
	function automatic logic [13:0] to_display(input mmss_t t);
		logic [13:0] m;
		m = 14'(t.minutes);
		return (m << 6) + (m << 5) + (m << 2) + 14'(t.seconds);
	endfunction

endpackage

// File: sv/kctc_if.sv
// Channel interfaces of the knob countdown timer controller.
// Event channel and result channel, each with valid/ready handshake.
// No dependencies.
interface kctc_evt_if;
	logic       valid;
	logic       ready;
	logic [1:0] op;
	logic [7:0] knob_sample;

	modport source (output valid, output op, output knob_sample, input ready);
	modport sink   (input valid, input op, input knob_sample, output ready);
endinterface

interface kctc_res_if;
	logic        valid;
	logic        ready;
	logic [1:0]  mode;
	logic [13:0] shown_time;
	logic        digits_blank;
	logic        saver_active;
	logic [2:0]  saver_position;
	logic        beeper_on;
	logic        start_conversion;
	logic        enter_power_down;

	modport source (output valid, output mode, output shown_time, output digits_blank,
		output saver_active, output saver_position, output beeper_on,
		output start_conversion, output enter_power_down, input ready);
	modport sink   (input valid, input mode, input shown_time, input digits_blank,
		input saver_active, input saver_position, input beeper_on,
		input start_conversion, input enter_power_down, output ready);
endinterface

// File: sv/kctc_knob.sv
// Knob sample smoothing and mapping of the averaged knob position to a time.
// Depends on kctc_pkg.
module kctc_knob #(
	parameter int SAMPLES_PER_SET = 10,
	parameter int KNOB_STEPS      = 40
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                fire,
	input  kctc_pkg::op_t       op,
	input  logic [7:0]          knob_sample,
	input  kctc_pkg::mode_t     mode,
	output kctc_pkg::knob_stat_t stat
);
	import kctc_pkg::*;

	localparam int STEP_W = $clog2(KNOB_STEPS + 1);
	localparam int PROD_W = 8 + STEP_W;
	localparam logic [3:0] SPS_C = 4'(SAMPLES_PER_SET);

	logic [3:0]        cnt_q;
	logic [7:0]        avg_q;
	mmss_t             knob_q;

	logic              is_sample;
	logic [3:0]        cnt_inc;
	logic              set_done;
	logic [8:0]        avg_sum;
	logic [PROD_W-1:0] prod;
	logic [PROD_W:0]   quot_sum;
	logic [STEP_W-1:0] steps;
	logic [7:0]        st8;
	logic [7:0]        min8;
	mmss_t             mapped;

	assign is_sample = fire && (op == OP_SAMPLE) && (mode != MODE_DOWN);
	assign cnt_inc   = cnt_q + 4'd1;
	assign set_done  = (cnt_inc >= SPS_C);
	assign avg_sum   = {1'b0, avg_q} + {1'b0, knob_sample};

	// Position in knob steps: average times steps divided by 255.
	assign prod     = PROD_W'(avg_q) * PROD_W'(KNOB_STEPS);
	assign quot_sum = {1'b0, prod} + (PROD_W+1)'(prod >> 8) + (PROD_W+1)'(1);
	assign steps    = STEP_W'(quot_sum >> 8);
	assign st8      = 8'(steps);

	// Piecewise map: 30 s steps to 5 min, 1 min steps to 20 min, then 5 min steps.
	always_comb begin
		mapped.seconds = '0;
		if (st8 <= 8'd10) begin
			min8 = st8 >> 1;
			mapped.seconds = st8[0] ? SEC_W'(30) : '0;
		end else if (st8 <= 8'd25) begin
			min8 = st8 - 8'd5;
		end else begin
			min8 = st8 + (st8 << 2) - 8'd105;
		end
		mapped.minutes = MIN_W'(min8);
	end

	// Sample counter, running average and mapped knob time.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			avg_q  <= '0;
			knob_q <= '0;
		end else if (is_sample) begin
			if (set_done) begin
				cnt_q  <= '0;
				knob_q <= mapped;
			end else begin
				cnt_q <= cnt_inc;
				avg_q <= avg_sum[8:1];
			end
		end
	end

	assign stat.cur  = knob_q;
	assign stat.nxt  = (is_sample && set_done) ? mapped : knob_q;
	assign stat.conv = is_sample && (!set_done || mode == MODE_SETTING);

endmodule

// File: sv/kctc_timer.sv
// Mode control, countdown, blink, beep pattern, saver and idle power down.
// Builds the result transaction. Depends on kctc_pkg.
module kctc_timer (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 fire,
	input  kctc_pkg::op_t        op,
	input  kctc_pkg::cfg_t       cfg,
	input  kctc_pkg::knob_stat_t knob,
	output kctc_pkg::mode_t      mode,
	output kctc_pkg::res_t       result
);
	import kctc_pkg::*;

	mode_t       mode_q, mode_nx;
	logic [15:0] sub_q, sub_nx;
	mmss_t       rem_q, rem_nx;
	logic [15:0] blink_q, blink_nx;
	logic        vis_q, vis_nx;
	logic [15:0] idle_s_q, idle_s_nx;
	logic [15:0] idle_b_q, idle_b_nx;
	logic        beep_q, beep_nx;
	logic [15:0] bcnt_q, bcnt_nx;
	logic [2:0]  phase_q, phase_nx;
	logic        saver_q, saver_nx;
	logic [7:0]  ssec_q, ssec_nx;
	logic [2:0]  dot_q, dot_nx;
	logic        down;
	logic        conv_btn;
	logic [15:0] limit;
	logic        saver_on;

	// Next state for the event in the input stage.
	always_comb begin
		mode_nx   = mode_q;
		sub_nx    = sub_q;
		rem_nx    = rem_q;
		blink_nx  = blink_q;
		vis_nx    = vis_q;
		idle_s_nx = idle_s_q;
		idle_b_nx = idle_b_q;
		beep_nx   = beep_q;
		bcnt_nx   = bcnt_q;
		phase_nx  = phase_q;
		saver_nx  = saver_q;
		ssec_nx   = ssec_q;
		dot_nx    = dot_q;
		down      = 1'b0;
		conv_btn  = 1'b0;
		limit     = cfg.beep_on_ticks;
		if (fire && mode_q == MODE_DOWN) begin
			if (op == OP_WAKE) begin
				idle_s_nx = '0;
				idle_b_nx = '0;
				mode_nx   = MODE_WORKING;
			end
		end else if (fire) begin
			case (op)
				OP_TICK: begin
					// Countdown second and saver.
					if (mode_q == MODE_WORKING && !beep_q) begin
						sub_nx = inc_sat(sub_q);
						if (sub_nx >= cfg.ticks_per_second) begin
							sub_nx = '0;
							if (rem_q.seconds != '0) begin
								rem_nx.seconds = rem_q.seconds - SEC_W'(1);
							end else if (rem_q.minutes != '0) begin
								rem_nx.minutes = rem_q.minutes - MIN_W'(1);
								rem_nx.seconds = SEC_W'(59);
							end
							if (rem_nx.minutes == '0 && rem_nx.seconds == '0) begin
								beep_nx = 1'b1;
							end
							if (!saver_q) begin
								if (ssec_q >= cfg.saver_delay_seconds) begin
									saver_nx = 1'b1;
									ssec_nx  = '0;
								end else begin
									ssec_nx = ssec_q + 8'd1;
								end
							end else begin
								dot_nx = (dot_q >= 3'd4) ? 3'd1 : dot_q + 3'd1;
							end
						end
					end
					// Display blink and idle count while setting.
					if (mode_q == MODE_SETTING) begin
						blink_nx = inc_sat(blink_q);
						if (!vis_q && blink_nx >= cfg.blink_off_ticks) begin
							blink_nx = '0;
							vis_nx   = 1'b1;
						end else if (vis_q && blink_nx >= cfg.blink_on_ticks) begin
							blink_nx = '0;
							vis_nx   = 1'b0;
						end
						idle_s_nx = inc_sat(idle_s_q);
					end
					// Beep pattern: pause in phase zero, then beeps and gaps.
					if (beep_nx) begin
						limit   = (phase_q == 3'd0) ? cfg.beep_pause_ticks : cfg.beep_on_ticks;
						bcnt_nx = inc_sat(bcnt_q);
						if (bcnt_nx >= limit) begin
							phase_nx = phase_q + 3'd1;
							bcnt_nx  = '0;
						end
						idle_b_nx = inc_sat(idle_b_q);
					end
					// Idle timeout enters power down.
					if (idle_s_nx >= cfg.idle_setting_ticks ||
					    idle_b_nx >= cfg.idle_beeping_ticks) begin
						mode_nx  = MODE_DOWN;
						beep_nx  = 1'b0;
						phase_nx = '0;
						bcnt_nx  = '0;
						down     = 1'b1;
					end
				end
				OP_BUTTON: begin
					if (mode_q == MODE_SETTING) begin
						rem_nx    = knob.cur;
						mode_nx   = MODE_WORKING;
						saver_nx  = 1'b0;
						idle_s_nx = '0;
						idle_b_nx = '0;
						if (knob.cur.minutes == '0 && knob.cur.seconds == '0) begin
							beep_nx = 1'b1;
						end
					end else begin
						if (beep_q || !saver_q) begin
							mode_nx  = MODE_SETTING;
							conv_btn = 1'b1;
						end else begin
							saver_nx = 1'b0;
							ssec_nx  = '0;
						end
						beep_nx  = 1'b0;
						phase_nx = '0;
						bcnt_nx  = '0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// State registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_SETTING;
			sub_q    <= '0;
			rem_q    <= '0;
			blink_q  <= '0;
			vis_q    <= 1'b1;
			idle_s_q <= '0;
			idle_b_q <= '0;
			beep_q   <= 1'b0;
			bcnt_q   <= '0;
			phase_q  <= '0;
			saver_q  <= 1'b0;
			ssec_q   <= '0;
			dot_q    <= 3'd1;
		end else begin
			mode_q   <= mode_nx;
			sub_q    <= sub_nx;
			rem_q    <= rem_nx;
			blink_q  <= blink_nx;
			vis_q    <= vis_nx;
			idle_s_q <= idle_s_nx;
			idle_b_q <= idle_b_nx;
			beep_q   <= beep_nx;
			bcnt_q   <= bcnt_nx;
			phase_q  <= phase_nx;
			saver_q  <= saver_nx;
			ssec_q   <= ssec_nx;
			dot_q    <= dot_nx;
		end
	end

	assign mode = mode_q;

	// Result fields from the state after this event.
	assign saver_on = (mode_nx == MODE_WORKING) && saver_nx;

	always_comb begin
		case (mode_nx)
			MODE_SETTING: begin
				result.mode       = MODE_CODE_SETTING;
				result.shown_time = to_display(knob.nxt);
			end
			MODE_WORKING: begin
				result.mode       = MODE_CODE_WORKING;
				result.shown_time = to_display(rem_nx);
			end
			default: begin
				result.mode       = MODE_CODE_DOWN;
				result.shown_time = '0;
			end
		endcase
		result.digits_blank     = (mode_nx == MODE_SETTING && !vis_nx) || (mode_nx == MODE_DOWN);
		result.saver_active     = saver_on;
		result.saver_position   = saver_on ? dot_nx : 3'd1;
		result.beeper_on        = beep_nx && phase_nx[0];
		result.start_conversion = conv_btn || knob.conv;
		result.enter_power_down = down;
	end

`ifndef ASSERT_OFF
	// The beep pattern only runs while counting mode is active.
	a_beep_working: assert property (@(posedge clk) disable iff (!arst_n)
		beep_q |-> mode_q == MODE_WORKING)
		else $error("beeping outside working mode");

	// Power down ignores everything but a wake event.
	a_down_holds: assert property (@(posedge clk) disable iff (!arst_n)
		fire && mode_q == MODE_DOWN && op != OP_WAKE
		|=> mode_q == MODE_DOWN && $stable(rem_q) && $stable(idle_s_q))
		else $error("state changed in power down");

	// Entering power down stops the beeper and restarts its pattern.
	a_down_entry: assert property (@(posedge clk) disable iff (!arst_n)
		fire && down |=> mode_q == MODE_DOWN && !beep_q && phase_q == 3'd0 && bcnt_q == '0)
		else $error("power down entry left beep state");

	// The saver dot stays on one of the four digits.
	a_dot_range: assert property (@(posedge clk) disable iff (!arst_n)
		dot_q >= 3'd1 && dot_q <= 3'd4)
		else $error("saver dot out of range");
`endif

endmodule

// File: sv/knob_countdown_timer_controller.sv
// Top level of the knob countdown timer controller: input stage, result stage,
// configuration registers. Depends on kctc_pkg, kctc_if, kctc_knob, kctc_timer.
//
//  Channel  Dir  Handshake        Payload
//  evt      in   valid/ready      op, knob_sample
//  res      out  valid/ready      mode, shown_time, digits_blank, saver_active,
//                                 saver_position, beeper_on, start_conversion,
//                                 enter_power_down
//  cfg      in   cfg_we           cfg_index, cfg_data
//
// Each event transaction gives one result transaction: it waits in the input
// register, then the whole state update goes in one pass into the result register.
// One event is taken per cycle as long as results are taken. A stalled result
// holds the result register; the input register keeps one more event and then
// ready drops. Reset sets state, valid bits and config to defaults, not payloads.
module knob_countdown_timer_controller #(
	parameter int SAMPLES_PER_SET = 10,
	parameter int KNOB_STEPS      = 40
) (
	input  logic        clk,
	input  logic        arst_n,
	kctc_evt_if.sink    evt,
	kctc_res_if.source  res,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import kctc_pkg::*;

	logic       v_s1;
	op_t        op_s1;
	logic [7:0] sample_s1;
	logic       v_s2;
	res_t       res_s2;

	cfg_t       cfg_q;
	logic       fire;
	mode_t      mode;
	knob_stat_t knob_stat;
	res_t       result;

	assign fire      = v_s1 && (!v_s2 || res.ready);
	assign evt.ready = !v_s1 || fire;

	// Input stage valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (evt.valid && evt.ready) begin
			v_s1 <= 1'b1;
		end else if (fire) begin
			v_s1 <= 1'b0;
		end
	end

	// Input stage payload.
	always_ff @(posedge clk) begin
		if (evt.valid && evt.ready) begin
			op_s1     <= op_t'(evt.op);
			sample_s1 <= evt.knob_sample;
		end
	end

	// Result stage valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (fire) begin
			v_s2 <= 1'b1;
		end else if (res.ready) begin
			v_s2 <= 1'b0;
		end
	end

	// Result stage payload.
	always_ff @(posedge clk) begin
		if (fire) begin
			res_s2 <= result;
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ticks_per_second    <= RST_TICKS_PER_SECOND;
			cfg_q.blink_on_ticks      <= RST_BLINK_ON_TICKS;
			cfg_q.blink_off_ticks     <= RST_BLINK_OFF_TICKS;
			cfg_q.beep_on_ticks       <= RST_BEEP_ON_TICKS;
			cfg_q.beep_pause_ticks    <= RST_BEEP_PAUSE_TICKS;
			cfg_q.idle_setting_ticks  <= RST_IDLE_SETTING_TICKS;
			cfg_q.idle_beeping_ticks  <= RST_IDLE_BEEPING_TICKS;
			cfg_q.saver_delay_seconds <= RST_SAVER_DELAY_SECONDS;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_TICKS_PER_SECOND:    cfg_q.ticks_per_second    <= cfg_data;
				CFG_BLINK_ON_TICKS:      cfg_q.blink_on_ticks      <= cfg_data;
				CFG_BLINK_OFF_TICKS:     cfg_q.blink_off_ticks     <= cfg_data;
				CFG_BEEP_ON_TICKS:       cfg_q.beep_on_ticks       <= cfg_data;
				CFG_BEEP_PAUSE_TICKS:    cfg_q.beep_pause_ticks    <= cfg_data;
				CFG_IDLE_SETTING_TICKS:  cfg_q.idle_setting_ticks  <= cfg_data;
				CFG_IDLE_BEEPING_TICKS:  cfg_q.idle_beeping_ticks  <= cfg_data;
				CFG_SAVER_DELAY_SECONDS: cfg_q.saver_delay_seconds <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	kctc_knob #(
		.SAMPLES_PER_SET (SAMPLES_PER_SET),
		.KNOB_STEPS      (KNOB_STEPS)
	) u_knob (
		.clk         (clk),
		.arst_n      (arst_n),
		.fire        (fire),
		.op          (op_s1),
		.knob_sample (sample_s1),
		.mode        (mode),
		.stat        (knob_stat)
	);

	kctc_timer u_timer (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.op     (op_s1),
		.cfg    (cfg_q),
		.knob   (knob_stat),
		.mode   (mode),
		.result (result)
	);

	// Result channel.
	assign res.valid            = v_s2;
	assign res.mode             = res_s2.mode;
	assign res.shown_time       = res_s2.shown_time;
	assign res.digits_blank     = res_s2.digits_blank;
	assign res.saver_active     = res_s2.saver_active;
	assign res.saver_position   = res_s2.saver_position;
	assign res.beeper_on        = res_s2.beeper_on;
	assign res.start_conversion = res_s2.start_conversion;
	assign res.enter_power_down = res_s2.enter_power_down;

endmodule
